@@ sv/bounded_priority_job_queue_assert.svh @@
// Assertion macros used by the job queue datapath.
`ifndef BOUNDED_PRIORITY_JOB_QUEUE_ASSERT_SVH
`define BOUNDED_PRIORITY_JOB_QUEUE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define BPJQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that forces a consequence in the next cycle.
`define BPJQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bpjq_pkg.sv @@
package bpjq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int PRI_W     = 16;
    localparam int IN_PAY_W  = 32;
    localparam int ST_W      = 2;
    localparam int OUT_PAY_W = 32;
    localparam int CNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_BADPRI = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic decide;
        logic init_k;
        logic rd_k;
        logic rd_head;
        logic wr_shift;
        logic wr_new;
        logic dec_k;
        logic inc_occ;
        logic capture;
        logic dec_occ;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             in_valid;
        logic [CMD_W-1:0] op;
        logic             pri_zero;
        logic             full;
        logic             empty;
        logic             k_zero;
        logic             shift_ok;
        logic             out_free;
    } ctrl_sts_t;

endpackage

@@ sv/bpjq_req_if.sv @@
interface bpjq_req_if;
    logic                           valid;
    logic                           ready;
    logic [bpjq_pkg::CMD_W-1:0]     command;
    logic [bpjq_pkg::PRI_W-1:0]     job_priority;
    logic [bpjq_pkg::IN_PAY_W-1:0]  job_payload;

    modport source (output valid, output command, output job_priority, output job_payload,
                    input ready);
    modport sink (input valid, input command, input job_priority, input job_payload,
                  output ready);
endinterface

@@ sv/bpjq_rsp_if.sv @@
interface bpjq_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bpjq_pkg::ST_W-1:0]       status;
    logic [bpjq_pkg::PRI_W-1:0]      head_priority;
    logic [bpjq_pkg::OUT_PAY_W-1:0]  head_payload;
    logic [bpjq_pkg::CNT_OUT_W-1:0]  job_count;
    logic [bpjq_pkg::CNT_OUT_W-1:0]  free_slots;

    modport source (output valid, output status, output head_priority, output head_payload,
                    output job_count, output free_slots, input ready);
    modport sink (input valid, input status, input head_priority, input head_payload,
                  input job_count, input free_slots, output ready);
endinterface

@@ sv/bpjq_ctrl.sv @@
module bpjq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpjq_pkg::ctrl_sts_t   sts,
    output bpjq_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_HEAD   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.op == bpjq_pkg::CMD_ENQ && !sts.pri_zero && !sts.full)
                begin
                    cmd.init_k = 1'b1;
                    state_next = S_SCAN;
                end
                else if ((sts.op == bpjq_pkg::CMD_DEQ || sts.op == bpjq_pkg::CMD_PEEK)
                         && !sts.empty)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_HEAD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                // The new job lands in slot 0 once every held job has moved up.
                if (sts.k_zero)
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.inc_occ = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.shift_ok)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.dec_k    = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.inc_occ = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_HEAD:
            begin
                cmd.capture = 1'b1;
                cmd.dec_occ = (sts.op == bpjq_pkg::CMD_DEQ);
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/bpjq_datapath.sv @@
`include "bounded_priority_job_queue_assert.svh"

module bpjq_datapath #(
    parameter int QUEUE_DEPTH  = bpjq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = bpjq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bpjq_req_if.sink              req,
    bpjq_rsp_if.source            rsp,
    input  bpjq_pkg::ctrl_cmd_t   cmd,
    output bpjq_pkg::ctrl_sts_t   sts
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PRI_W  = bpjq_pkg::PRI_W;
    localparam int WORD_W = PRI_W + PAYLOAD_BITS;

    // Slot words hold the priority above the payload.
    logic [WORD_W-1:0]             slot_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0]             rd_data_reg;

    logic [bpjq_pkg::CMD_W-1:0]    op_reg;
    logic [PRI_W-1:0]              pri_reg;
    logic [PAYLOAD_BITS-1:0]       pay_reg;
    logic [CNT_W-1:0]              occ_reg;
    logic [CNT_W-1:0]              occ_next;
    logic [CNT_W-1:0]              k_reg;
    logic [bpjq_pkg::ST_W-1:0]     st_reg;
    logic [bpjq_pkg::ST_W-1:0]     st_next;
    logic [PRI_W-1:0]              head_pri_reg;
    logic [PAYLOAD_BITS-1:0]       head_pay_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic [63:0]                   pay_in_wide;
    logic [63:0]                   head_pay_wide;
    logic [31:0]                   cnt_wide;
    logic [31:0]                   free_wide;
    logic [CNT_W-1:0]              rd_cnt;
    logic [IDX_W-1:0]              rd_addr;
    logic [IDX_W-1:0]              wr_addr;
    logic [WORD_W-1:0]             wr_data;
    logic                          mem_we;
    logic                          rd_req;
    logic                          out_free;

    assign pay_in_wide   = 64'(req.job_payload);
    assign head_pay_wide = 64'(head_pay_reg);
    assign cnt_wide      = 32'(occ_reg);
    assign free_wide     = 32'(QUEUE_DEPTH) - cnt_wide;

    assign out_free = !out_valid_reg || rsp.ready;

    assign sts.in_valid = req.valid;
    assign sts.op       = op_reg;
    assign sts.pri_zero = (pri_reg == '0);
    assign sts.full     = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.empty    = (occ_reg == '0);
    assign sts.k_zero   = (k_reg == '0);
    // Jobs of equal or smaller priority value sit above the new one.
    assign sts.shift_ok = (rd_data_reg[WORD_W-1 -: PRI_W] <= pri_reg);
    assign sts.out_free = out_free;

    assign req.ready = cmd.in_ready;

    // The head read looks at the top occupied slot, the scan at the slot below k.
    assign rd_cnt  = cmd.rd_head ? (occ_reg - CNT_W'(1)) : (k_reg - CNT_W'(1));
    assign rd_addr = rd_cnt[IDX_W-1:0];
    assign rd_req  = cmd.rd_head || cmd.rd_k;
    assign wr_addr = k_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_shift ? rd_data_reg : {pri_reg, pay_reg};
    assign mem_we  = cmd.wr_shift || cmd.wr_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_comb
    begin
        st_next = bpjq_pkg::ST_OK;
        unique case (op_reg) inside
            bpjq_pkg::CMD_ENQ:
            begin
                if (sts.pri_zero)
                begin
                    st_next = bpjq_pkg::ST_BADPRI;
                end
                else if (sts.full)
                begin
                    st_next = bpjq_pkg::ST_FULL;
                end
            end
            bpjq_pkg::CMD_DEQ, bpjq_pkg::CMD_PEEK:
            begin
                if (sts.empty)
                begin
                    st_next = bpjq_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                st_next = bpjq_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.inc_occ)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (cmd.dec_occ)
        begin
            occ_next = occ_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cmd.init_k)
            begin
                k_reg <= occ_reg;
            end
            else if (cmd.dec_k)
            begin
                k_reg <= k_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= req.command;
            pri_reg <= req.job_priority;
            pay_reg <= pay_in_wide[PAYLOAD_BITS-1:0];
        end
        if (cmd.decide)
        begin
            st_reg       <= st_next;
            head_pri_reg <= '0;
            head_pay_reg <= '0;
        end
        else if (cmd.capture)
        begin
            head_pri_reg <= rd_data_reg[WORD_W-1 -: PRI_W];
            head_pay_reg <= rd_data_reg[PAYLOAD_BITS-1:0];
        end
        if (cmd.load_out)
        begin
            rsp.status        <= st_reg;
            rsp.head_priority <= head_pri_reg;
            rsp.head_payload  <= head_pay_wide[bpjq_pkg::OUT_PAY_W-1:0];
            rsp.job_count     <= cnt_wide[bpjq_pkg::CNT_OUT_W-1:0];
            rsp.free_slots    <= free_wide[bpjq_pkg::CNT_OUT_W-1:0];
        end
    end

    assign rsp.valid = out_valid_reg;

    `BPJQ_ASSERT(a_occ_bound, occ_reg <= CNT_W'(QUEUE_DEPTH), "occupancy above depth")
    `BPJQ_ASSERT(a_scan_bound, !cmd.rd_k || k_reg <= occ_reg, "scan pointer above occupancy")
    `BPJQ_ASSERT(a_ins_room, !cmd.wr_new || occ_reg < CNT_W'(QUEUE_DEPTH), "insert into full queue")
    `BPJQ_ASSERT_NEXT(a_deq_count, cmd.dec_occ, occ_reg == $past(occ_reg) - CNT_W'(1), "dequeue count")

endmodule

@@ sv/bounded_priority_job_queue.sv @@
// Channel  Direction  Contents
// req      in         command, job_priority, job_payload
// rsp      out        status, head_priority, head_payload, job_count, free_slots
//
// One item is worked on at a time; every item gives exactly one result item.
// Dequeue and peek pass through IDLE, DECIDE, HEAD and RESP; a rejected or unused command skips HEAD.
// An enqueue scans down from the top, moving jobs of equal or smaller priority value up a slot,
// through the single slot memory with its registered read: each moved job costs a read and a write.
// Reset empties the queue at once; the slot memory itself is not cleared.
// A waiting result stalls only the end of the next item, not its acceptance.
module bounded_priority_job_queue #(
    parameter int QUEUE_DEPTH  = bpjq_pkg::QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_BITS = bpjq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bpjq_req_if.sink    req,
    bpjq_rsp_if.source  rsp
);

    bpjq_pkg::ctrl_cmd_t cmd;
    bpjq_pkg::ctrl_sts_t sts;

    bpjq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bpjq_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

@@ tb/sv/bpjq_result_checker.sv @@
module bpjq_result_checker (
    input  logic  clk,
    input  logic  rst_n,
    bpjq_req_if   req,
    bpjq_rsp_if   rsp,
    output int    mismatch_count,
    output int    replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import bpjq_pkg::*;

    typedef struct {
        logic [PRI_W-1:0]     rank;
        logic [IN_PAY_W-1:0]  payload;
    } job_t;

    typedef struct {
        logic [ST_W-1:0]       status;
        logic [PRI_W-1:0]      head_priority;
        logic [OUT_PAY_W-1:0]  head_payload;
        logic [CNT_OUT_W-1:0]  job_count;
        logic [CNT_OUT_W-1:0]  free_slots;
    } reply_t;

    // Held jobs in service order: index 0 is the next job to leave.
    job_t   queued_jobs[$];
    reply_t expected_replies[$];
    int     failures = 0;
    int     owed = 0;

    assign mismatch_count = failures;
    assign replies_owed   = owed;

    function automatic reply_t serve_command(input logic [CMD_W-1:0] cmd,
                                             input logic [PRI_W-1:0] rank,
                                             input logic [IN_PAY_W-1:0] payload);
        reply_t r;
        job_t   fresh;
        int     slot;
        r.status        = ST_OK;
        r.head_priority = '0;
        r.head_payload  = '0;
        case (cmd)
            CMD_ENQ:
            begin
                if (rank == '0)
                    r.status = ST_BADPRI;
                else if (queued_jobs.size() >= QUEUE_DEPTH_DEF)
                    r.status = ST_FULL;
                else
                begin
                    // A new job goes behind every job of the same or better rank.
                    slot = 0;
                    while (slot < queued_jobs.size() && queued_jobs[slot].rank <= rank)
                        slot++;
                    fresh.rank    = rank;
                    fresh.payload = payload;
                    queued_jobs.insert(slot, fresh);
                end
            end
            CMD_DEQ, CMD_PEEK:
            begin
                if (queued_jobs.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.head_priority = queued_jobs[0].rank;
                    r.head_payload  = OUT_PAY_W'(queued_jobs[0].payload);
                    if (cmd == CMD_DEQ)
                        void'(queued_jobs.pop_front());
                end
            end
            default:
            begin
            end
        endcase
        r.job_count  = CNT_OUT_W'(queued_jobs.size());
        r.free_slots = CNT_OUT_W'(QUEUE_DEPTH_DEF - queued_jobs.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            queued_jobs.delete();
            expected_replies.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                expected_replies.push_back(serve_command(req.command, req.job_priority,
                                                         req.job_payload));
            if (rsp.valid && rsp.ready)
            begin
                got.status        = rsp.status;
                got.head_priority = rsp.head_priority;
                got.head_payload  = rsp.head_payload;
                got.job_count     = rsp.job_count;
                got.free_slots    = rsp.free_slots;
                if (expected_replies.size() == 0)
                begin
                    $error("result item with no command waiting: status %0d", got.status);
                    failures++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.head_priority !== want.head_priority)
                    begin
                        $error("head_priority: expected %0d, got %0d",
                               want.head_priority, got.head_priority);
                        failures++;
                    end
                    if (got.head_payload !== want.head_payload)
                    begin
                        $error("head_payload: expected %08h, got %08h",
                               want.head_payload, got.head_payload);
                        failures++;
                    end
                    if (got.job_count !== want.job_count)
                    begin
                        $error("job_count: expected %0d, got %0d", want.job_count, got.job_count);
                        failures++;
                    end
                    if (got.free_slots !== want.free_slots)
                    begin
                        $error("free_slots: expected %0d, got %0d",
                               want.free_slots, got.free_slots);
                        failures++;
                    end
                end
            end
        end
        owed = expected_replies.size();
    end

endmodule

@@ tb/sv/bounded_priority_job_queue_test.sv @@
module bounded_priority_job_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpjq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1425;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic clk;
    logic rst_n;

    bpjq_req_if req_bus ();
    bpjq_rsp_if rsp_bus ();

    int failures_seen;
    int replies_owed;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit steady_run = 1'b0;

    bounded_priority_job_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    bpjq_result_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_bus),
        .rsp            (rsp_bus),
        .mismatch_count (failures_seen),
        .replies_owed   (replies_owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** bounded_priority_job_queue: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady_run || pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [PRI_W-1:0] rank,
                         input logic [IN_PAY_W-1:0] payload);
        int gap;
        req_bus.valid        <= 1'b1;
        req_bus.command      <= cmd;
        req_bus.job_priority <= rank;
        req_bus.job_payload  <= payload;
        do
            @(posedge clk);
        while (!req_bus.ready);
        items_sent++;
        gap = idle_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result side: random stalls, plus one long hold-off while commands keep coming.
    initial
    begin
        bit held_long;
        int on_len;
        int off_len;
        int pick;
        held_long = 1'b0;
        rsp_bus.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (!held_long && items_sent >= 300)
            begin
                held_long = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                pick   = $urandom_range(0, 99);
                on_len = (pick < 15) ? $urandom_range(50, 150) : $urandom_range(1, 24);
                pick   = $urandom_range(0, 99);
                if (pick < 55)
                    off_len = 0;
                else if (pick < 90)
                    off_len = $urandom_range(1, 4);
                else
                    off_len = $urandom_range(10, 60);
                rsp_bus.ready <= 1'b1;
                repeat (on_len) @(posedge clk);
                if (off_len > 0)
                begin
                    rsp_bus.ready <= 1'b0;
                    repeat (off_len) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0]    cmd;
        logic [PRI_W-1:0]    rank;
        logic [IN_PAY_W-1:0] payload;
        int enq_share;
        int pick;
        rst_n                <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.command      <= CMD_ENQ;
        req_bus.job_priority <= '0;
        req_bus.job_payload  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, zero priority and the unused command first.
        offer(CMD_PEEK, 16'hFFFF, 32'hFFFF_FFFF);
        offer(CMD_DEQ, '0, '0);
        offer(CMD_ENQ, '0, 32'hFFFF_FFFF);
        offer(CMD_UNUSED, 16'hA5A5, $urandom());

        // Fill to the top with extreme values and many equal ranks.
        for (int k = 0; k < QUEUE_DEPTH_DEF; k++)
        begin
            rank    = (k == 0) ? 16'hFFFF : PRI_W'((k % 4) + 1);
            payload = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom();
            offer(CMD_ENQ, rank, payload);
        end
        offer(CMD_ENQ, 16'd1, $urandom());
        offer(CMD_ENQ, '0, $urandom());
        offer(CMD_UNUSED, '0, '0);
        offer(CMD_PEEK, '0, '0);
        offer(CMD_DEQ, '0, '0);

        // Random blocks that lean toward filling, mixing or draining the queue.
        enq_share = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                pick       = $urandom_range(0, 2);
                enq_share  = (pick == 0) ? 85 : (pick == 1) ? 50 : 20;
                steady_run = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < enq_share)
                cmd = CMD_ENQ;
            else if ($urandom_range(0, 2) == 0)
                cmd = CMD_PEEK;
            else
                cmd = CMD_DEQ;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                rank = '0;
            else if (pick < 6)
                rank = 16'hFFFF;
            else if (pick < 50)
                rank = PRI_W'($urandom_range(1, 6));
            else
                rank = PRI_W'($urandom_range(1, 65535));
            payload = $urandom();
            offer(cmd, rank, payload);
        end
        req_bus.valid <= 1'b0;

        do
            @(negedge clk);
        while (replies_owed != 0);
        repeat (40) @(posedge clk);
        @(negedge clk);
        if (failures_seen == 0)
            $display("** bounded_priority_job_queue: PASSED **");
        else
            $display("** bounded_priority_job_queue: FAILED **");
        $finish;
    end

endmodule
